@@ sv/spot_point_light_radiance_macros.svh @@
// Assertion helpers used by the light radiance RTL.
`ifndef SPOT_POINT_LIGHT_RADIANCE_MACROS_SVH
`define SPOT_POINT_LIGHT_RADIANCE_MACROS_SVH

// Concurrent check on an explicit clock and active-low reset.
`define SPRL_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Concurrent check on the block clock and reset.
`define SPRL_ASSERT(lbl, prop, msg) `SPRL_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ sv/sprl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sprl_pkg;

  // Field formats
  localparam int COORD_W = 16;           // signed Q8.8 coordinates
  localparam int FRAC_W  = 8;            // fraction bits of Q8.8
  localparam int LANE_W  = 16;           // coefficient, intensity and axis lanes
  localparam int CH_W    = 16;           // radiance channel width
  localparam int REG_W   = 48;           // widest config register
  localparam int IDX_W   = 3;            // config register index
  localparam int COS_W   = 16;           // Q1.14 cosines

  // Internal widths
  localparam int DIFF_W  = COORD_W + 1;          // light-to-point component
  localparam int SQ_W    = 2 * DIFF_W;           // squared distance, Q.16
  localparam int ROOT_W  = SQ_W / 2;             // distance, Q.8
  localparam int PR_W    = DIFF_W + LANE_W;      // component times axis lane
  localparam int DOT_W   = PR_W + 2;             // dot product sum
  localparam int DV_W    = 44;                   // attenuation divisor, Q.16
  localparam int CS_W    = ROOT_W + 2;           // signed cosine estimate
  localparam int W_FRAC  = 14;                   // cone weight fraction bits
  localparam int W_W     = W_FRAC + 1;           // cone weight 0..1.0

  localparam logic [W_W-1:0]  W_ONE      = W_W'(1) << W_FRAC;
  localparam logic [CH_W-1:0] CH_MAX     = '1;
  localparam int              ROUND_Q14  = 1 << (W_FRAC - 1);

  // Config register indexes
  localparam logic [IDX_W-1:0] REG_SPOT_MODE = 3'd0;
  localparam logic [IDX_W-1:0] REG_LIGHT_POS = 3'd1;
  localparam logic [IDX_W-1:0] REG_CONE_DIR  = 3'd2;
  localparam logic [IDX_W-1:0] REG_FALLOFF   = 3'd3;
  localparam logic [IDX_W-1:0] REG_INTENSITY = 3'd4;
  localparam logic [IDX_W-1:0] REG_COS_OUTER = 3'd5;
  localparam logic [IDX_W-1:0] REG_COS_INNER = 3'd6;

  // Pipeline latencies in register stages
  localparam int FRONT_LAT = 3 + ROOT_W;                    // diff, products, sum, root
  localparam int ATTEN_LAT = 4 + CH_W;                      // products, divisor, numerators, saturate, quotient
  localparam int CONE_LAT  = 1 + (ROOT_W + 1) + 2 + W_FRAC; // cosine, weight
  localparam int ALIGN     = CONE_LAT - ATTEN_LAT;
  localparam int PIPE_LAT  = FRONT_LAT + CONE_LAT + 2;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_z;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_x;
  } point_t;

  typedef struct packed {
    logic [CH_W-1:0] radiance_red;
    logic [CH_W-1:0] radiance_green;
    logic [CH_W-1:0] radiance_blue;
    logic            divisor_zero;
    logic            clipped;
  } result_t;

  typedef struct packed {
    logic                    spot_mode;
    logic [REG_W-1:0]        light_position;
    logic [REG_W-1:0]        cone_direction;
    logic [REG_W-1:0]        falloff;
    logic [REG_W-1:0]        intensity;
    logic signed [COS_W-1:0] cos_outer;
    logic signed [COS_W-1:0] cos_inner;
  } cfg_t;

  typedef struct packed {
    logic                    valid;
    logic [SQ_W-1:0]         s;
    logic [ROOT_W-1:0]       r;
    logic signed [DOT_W-1:0] dot;
  } front_t;

  typedef struct packed {
    logic                     valid;
    logic [2:0][CH_W-1:0]     ch;
    logic                     clip;
    logic                     dzero;
  } atten_t;

  typedef struct packed {
    logic           valid;
    logic [W_W-1:0] w;
  } cone_t;

endpackage

`default_nettype wire

@@ sv/spot_point_light_radiance.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Point/spot light radiance pipeline. One shading point word is taken on every cycle that
// start is high (busy is always low). Its radiance word is on result_o with done_o high
// for one cycle. Words come out in order, one result per point. The receiver cannot stall
// the block. The latency is set by the bit-per-stage distance square root (17 stages),
// followed by the bit-per-stage cosine divide (18 stages) and cone weight divide (14
// stages); the attenuation divide runs beside the cone path and is delayed to meet it.
// Configuration writes take effect on the next cycle and must only be made while no
// points are in flight.
module spot_point_light_radiance
  import sprl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  point_t           point_i,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0] cfg_data_i,
  output result_t          result_o,
  output logic             done_o
);

  `include "spot_point_light_radiance_macros.svh"

  localparam int PW = CH_W + W_W;

  cfg_t   cfg;
  front_t front;
  atten_t atten;
  cone_t  cone;

  assign busy = 1'b0;

  sprl_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  sprl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (start && !busy),
    .point_i    (point_i),
    .cfg_i      (cfg),
    .front_o    (front)
  );

  sprl_atten u_atten (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .front_i (front),
    .cfg_i   (cfg),
    .atten_o (atten)
  );

  sprl_cone u_cone (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .front_i (front),
    .cfg_i   (cfg),
    .cone_o  (cone)
  );

  // delay line to meet the cone weight
  atten_t al_q [ALIGN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < ALIGN; j++) al_q[j] <= '0;
    end else begin
      al_q[0] <= atten;
      for (int j = 1; j < ALIGN; j++) al_q[j] <= al_q[j-1];
    end
  end

  // weight multiply with rounding
  logic          m1_v_q;
  logic [PW-1:0] prod_d [3];
  logic [PW-1:0] prod_q [3];
  logic          dz_q, clip_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_d[i] = PW'(al_q[ALIGN-1].ch[i]) * PW'(cone.w) + PW'(ROUND_Q14);
    end
  end

  // output word
  result_t res_d, res_q;
  logic    done_q;

  always_comb begin
    res_d.radiance_red   = dz_q ? '0 : CH_W'(prod_q[0] >> W_FRAC);
    res_d.radiance_green = dz_q ? '0 : CH_W'(prod_q[1] >> W_FRAC);
    res_d.radiance_blue  = dz_q ? '0 : CH_W'(prod_q[2] >> W_FRAC);
    res_d.divisor_zero   = dz_q;
    res_d.clipped        = clip_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      m1_v_q <= cone.valid;
      done_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    dz_q   <= al_q[ALIGN-1].dzero;
    clip_q <= al_q[ALIGN-1].clip;
    res_q  <= res_d;
  end

  assign result_o = res_q;
  assign done_o   = done_q;

  // black word with no clip flag
  logic black_ok;

  assign black_ok = !result_o.clipped && (result_o.radiance_red == '0)
                    && (result_o.radiance_green == '0) && (result_o.radiance_blue == '0);

  `SPRL_ASSERT(a_latency, (start && !busy) |-> ##PIPE_LAT done_o, "result word missing")
  `SPRL_ASSERT(a_align, al_q[ALIGN-1].valid == cone.valid, "attenuation and cone out of step")
  `SPRL_ASSERT(a_black, (done_o && result_o.divisor_zero) |-> black_ok, "zero divisor not black")

endmodule

`default_nettype wire

@@ sv/sprl_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sprl_regs
  import sprl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0] cfg_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_d, cfg_q;

  // register write decode, unknown indexes dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SPOT_MODE: cfg_d.spot_mode      = cfg_data_i[0];
        REG_LIGHT_POS: cfg_d.light_position = cfg_data_i;
        REG_CONE_DIR:  cfg_d.cone_direction = cfg_data_i;
        REG_FALLOFF:   cfg_d.falloff        = cfg_data_i;
        REG_INTENSITY: cfg_d.intensity      = cfg_data_i;
        REG_COS_OUTER: cfg_d.cos_outer      = cfg_data_i[COS_W-1:0];
        REG_COS_INNER: cfg_d.cos_inner      = cfg_data_i[COS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spot_mode      <= 1'b1;
      cfg_q.light_position <= '0;
      cfg_q.cone_direction <= '0;
      cfg_q.falloff        <= REG_W'(256);
      cfg_q.intensity      <= '0;
      cfg_q.cos_outer      <= '0;
      cfg_q.cos_inner      <= COS_W'(16384);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ sv/sprl_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sprl_front
  import sprl_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  point_t point_i,
  input  cfg_t   cfg_i,
  output front_t front_o
);

  localparam int TRIAL_W = SQ_W + 2;

  typedef struct packed {
    logic [SQ_W-1:0]         rem;
    logic [ROOT_W-1:0]       root;
    logic [SQ_W-1:0]         s;
    logic signed [DOT_W-1:0] dot;
  } root_stage_t;

  logic signed [COORD_W-1:0] pt_lane  [3];
  logic signed [COORD_W-1:0] lp_lane  [3];
  logic signed [LANE_W-1:0]  dir_lane [3];

  assign pt_lane[0] = point_i.point_x;
  assign pt_lane[1] = point_i.point_y;
  assign pt_lane[2] = point_i.point_z;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign lp_lane[i]  = cfg_i.light_position[i*COORD_W +: COORD_W];
    assign dir_lane[i] = cfg_i.cone_direction[i*LANE_W +: LANE_W];
  end

  // stage 0: light-to-point vector
  logic                     f0_v_q;
  logic signed [DIFF_W-1:0] diff_d [3];
  logic signed [DIFF_W-1:0] diff_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_d[i] = {pt_lane[i][COORD_W-1], pt_lane[i]} - {lp_lane[i][COORD_W-1], lp_lane[i]};
    end
  end

  // stage 1: squares and axis products
  logic                   f1_v_q;
  logic signed [SQ_W-1:0] sq_d [3];
  logic signed [SQ_W-1:0] sq_q [3];
  logic signed [PR_W-1:0] pr_d [3];
  logic signed [PR_W-1:0] pr_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = diff_q[i] * diff_q[i];
      pr_d[i] = diff_q[i] * dir_lane[i];
    end
  end

  // stage 2 onward: sums, then one root bit per stage
  logic        rv_d [ROOT_W+1];
  logic        rv_q [ROOT_W+1];
  root_stage_t rs_d [ROOT_W+1];
  root_stage_t rs_q [ROOT_W+1];

  always_comb begin
    rv_d[0]      = f1_v_q;
    rs_d[0].s    = $unsigned(sq_q[0]) + $unsigned(sq_q[1]) + $unsigned(sq_q[2]);
    rs_d[0].rem  = $unsigned(sq_q[0]) + $unsigned(sq_q[1]) + $unsigned(sq_q[2]);
    rs_d[0].root = '0;
    rs_d[0].dot  = DOT_W'(pr_q[0]) + DOT_W'(pr_q[1]) + DOT_W'(pr_q[2]);
  end

  for (genvar j = 0; j < ROOT_W; j++) begin : g_root
    localparam int K = ROOT_W - 1 - j;
    logic [TRIAL_W-1:0] trial;
    logic               ge;
    // (root + 2^K)^2 - root^2 against the remaining radicand
    always_comb begin
      trial = (TRIAL_W'(rs_q[j].root) << (K + 1)) + (TRIAL_W'(1) << (2 * K));
      ge    = TRIAL_W'(rs_q[j].rem) >= trial;
      rs_d[j+1] = rs_q[j];
      if (ge) begin
        rs_d[j+1].rem  = SQ_W'(TRIAL_W'(rs_q[j].rem) - trial);
        rs_d[j+1].root = rs_q[j].root | (ROOT_W'(1) << K);
      end
    end
    assign rv_d[j+1] = rv_q[j];
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_v_q <= 1'b0;
      f1_v_q <= 1'b0;
      for (int j = 0; j <= ROOT_W; j++) rv_q[j] <= 1'b0;
    end else begin
      f0_v_q <= in_valid_i;
      f1_v_q <= f0_v_q;
      for (int j = 0; j <= ROOT_W; j++) rv_q[j] <= rv_d[j];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    sq_q   <= sq_d;
    pr_q   <= pr_d;
    rs_q   <= rs_d;
  end

  assign front_o.valid = rv_q[ROOT_W];
  assign front_o.s     = rs_q[ROOT_W].s;
  assign front_o.r     = rs_q[ROOT_W].root;
  assign front_o.dot   = rs_q[ROOT_W].dot;

endmodule

`default_nettype wire

@@ sv/sprl_atten.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sprl_atten
  import sprl_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  front_t front_i,
  input  cfg_t   cfg_i,
  output atten_t atten_o
);

  localparam int PROD_W = LANE_W + ROOT_W;
  localparam int QS_W   = PROD_W + ROOT_W;
  localparam int DS_W   = DV_W + CH_W;

  typedef struct packed {
    logic [2:0][DV_W-1:0] rem;
    logic [2:0][CH_W-1:0] q;
    logic [2:0]           sat;
    logic [DV_W-1:0]      dv;
    logic                 dz;
  } div_stage_t;

  logic [LANE_W-1:0] c_lane, l_lane, qd_lane;
  logic [LANE_W-1:0] int_lane [3];

  assign c_lane  = cfg_i.falloff[0 +: LANE_W];
  assign l_lane  = cfg_i.falloff[LANE_W +: LANE_W];
  assign qd_lane = cfg_i.falloff[2*LANE_W +: LANE_W];

  for (genvar i = 0; i < 3; i++) begin : g_int
    assign int_lane[i] = cfg_i.intensity[i*LANE_W +: LANE_W];
  end

  // stage A1: linear and split quadratic products
  logic              a1_v_q;
  logic [PROD_W-1:0] lr_d, plo_d, phi_d;
  logic [PROD_W-1:0] lr_q, plo_q, phi_q;

  assign lr_d  = PROD_W'(l_lane) * PROD_W'(front_i.r);
  assign plo_d = PROD_W'(qd_lane) * PROD_W'(front_i.s[ROOT_W-1:0]);
  assign phi_d = PROD_W'(qd_lane) * PROD_W'(front_i.s[SQ_W-1:ROOT_W]);

  // stage A2: divisor in Q.16
  logic            a2_v_q;
  logic [QS_W-1:0] qs;
  logic [DV_W-1:0] dv_d, dv_q;

  always_comb begin
    qs   = {phi_q, {ROOT_W{1'b0}}} + QS_W'(plo_q);
    dv_d = DV_W'({c_lane, {FRAC_W{1'b0}}}) + DV_W'(lr_q) + DV_W'(qs >> FRAC_W);
  end

  // stage A3: rounded numerators
  logic            a3_v_q;
  logic [DV_W-1:0] num_d [3];
  logic [DV_W-1:0] num_q [3];
  logic [DV_W-1:0] dv3_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_d[i] = DV_W'({int_lane[i], {(2*FRAC_W){1'b0}}}) + (dv_q >> 1);
    end
  end

  // saturation test, then one quotient bit per stage
  logic       dvv_d [CH_W+1];
  logic       dvv_q [CH_W+1];
  div_stage_t ds_d  [CH_W+1];
  div_stage_t ds_q  [CH_W+1];

  always_comb begin
    dvv_d[0]   = a3_v_q;
    ds_d[0].dv = dv3_q;
    ds_d[0].dz = dv3_q == '0;
    ds_d[0].q  = '0;
    for (int i = 0; i < 3; i++) begin
      ds_d[0].rem[i] = num_q[i];
      ds_d[0].sat[i] = DS_W'(num_q[i]) >= {dv3_q, {CH_W{1'b0}}};
    end
  end

  for (genvar j = 0; j < CH_W; j++) begin : g_div
    localparam int K = CH_W - 1 - j;
    logic [DS_W-1:0] dsh;
    always_comb begin
      dsh = DS_W'(ds_q[j].dv) << K;
      ds_d[j+1] = ds_q[j];
      for (int i = 0; i < 3; i++) begin
        if (DS_W'(ds_q[j].rem[i]) >= dsh) begin
          ds_d[j+1].rem[i] = DV_W'(DS_W'(ds_q[j].rem[i]) - dsh);
          ds_d[j+1].q[i]   = ds_q[j].q[i] | (CH_W'(1) << K);
        end
      end
    end
    assign dvv_d[j+1] = dvv_q[j];
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_v_q <= 1'b0;
      a2_v_q <= 1'b0;
      a3_v_q <= 1'b0;
      for (int j = 0; j <= CH_W; j++) dvv_q[j] <= 1'b0;
    end else begin
      a1_v_q <= front_i.valid;
      a2_v_q <= a1_v_q;
      a3_v_q <= a2_v_q;
      for (int j = 0; j <= CH_W; j++) dvv_q[j] <= dvv_d[j];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    lr_q  <= lr_d;
    plo_q <= plo_d;
    phi_q <= phi_d;
    dv_q  <= dv_d;
    num_q <= num_d;
    dv3_q <= dv_q;
    ds_q  <= ds_d;
  end

  // saturated channels read as the Q8.8 maximum
  always_comb begin
    atten_o.valid = dvv_q[CH_W];
    for (int i = 0; i < 3; i++) begin
      atten_o.ch[i] = ds_q[CH_W].sat[i] ? CH_MAX : ds_q[CH_W].q[i];
    end
    atten_o.clip  = (|ds_q[CH_W].sat) && !ds_q[CH_W].dz;
    atten_o.dzero = ds_q[CH_W].dz;
  end

endmodule

`default_nettype wire

@@ sv/sprl_cone.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sprl_cone
  import sprl_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  front_t front_i,
  input  cfg_t   cfg_i,
  output cone_t  cone_o
);

  localparam int QC_W = ROOT_W + 1;       // cosine quotient bits
  localparam int DT_W = DOT_W + 1;
  localparam int NB_W = CS_W + 1;         // cos_outer - cos
  localparam int DN_W = COS_W;            // |cos_outer - cos_inner|
  localparam int RW_W = DN_W + W_FRAC;    // weight dividend

  typedef struct packed {
    logic [DOT_W-1:0]  rem;
    logic [QC_W-1:0]   q;
    logic [ROOT_W-1:0] r;
    logic              neg;
    logic              zero;
  } cos_stage_t;

  typedef struct packed {
    logic [RW_W-1:0]   rem;
    logic [W_FRAC-1:0] q;
    logic [DN_W-1:0]   den;
    logic              fix;
    logic [W_W-1:0]    wv;
  } w_stage_t;

  // cosine: |dot| / r, one quotient bit per stage
  logic       cv_d [QC_W+1];
  logic       cv_q [QC_W+1];
  cos_stage_t cd_d [QC_W+1];
  cos_stage_t cd_q [QC_W+1];

  always_comb begin
    cv_d[0]      = front_i.valid;
    cd_d[0].neg  = front_i.dot[DOT_W-1];
    cd_d[0].rem  = front_i.dot[DOT_W-1] ? $unsigned(-front_i.dot) : $unsigned(front_i.dot);
    cd_d[0].q    = '0;
    cd_d[0].r    = front_i.r;
    cd_d[0].zero = front_i.r == '0;
  end

  for (genvar j = 0; j < QC_W; j++) begin : g_cos
    localparam int K = QC_W - 1 - j;
    logic [DT_W-1:0] rsh;
    always_comb begin
      rsh = DT_W'(cd_q[j].r) << K;
      cd_d[j+1] = cd_q[j];
      if (DT_W'(cd_q[j].rem) >= rsh) begin
        cd_d[j+1].rem = DOT_W'(DT_W'(cd_q[j].rem) - rsh);
        cd_d[j+1].q   = cd_q[j].q | (QC_W'(1) << K);
      end
    end
    assign cv_d[j+1] = cv_q[j];
  end

  // C1: signed cosine, oriented numerator and denominator
  logic                    c1_v_q;
  logic signed [CS_W-1:0]  cs;
  logic signed [DN_W:0]    den0;
  logic signed [NB_W-1:0]  numb;
  logic signed [NB_W-1:0]  nn_d, nn_q;
  logic [DN_W-1:0]         den_d, den_q;
  logic                    eq_d, eq_q, hard_d, hard_q, zero_q;

  always_comb begin
    cs     = cd_q[QC_W].neg ? -$signed(CS_W'(cd_q[QC_W].q)) : $signed(CS_W'(cd_q[QC_W].q));
    den0   = (DN_W+1)'(cfg_i.cos_outer) - (DN_W+1)'(cfg_i.cos_inner);
    numb   = NB_W'(cfg_i.cos_outer) - NB_W'(cs);
    nn_d   = den0[DN_W] ? -numb : numb;
    den_d  = den0[DN_W] ? DN_W'(-den0) : DN_W'(den0);
    eq_d   = cfg_i.cos_outer == cfg_i.cos_inner;
    hard_d = cs >= CS_W'(cfg_i.cos_inner);
  end

  // C2 onward: weight special cases, then one weight bit per stage
  logic     wv_d [W_FRAC+1];
  logic     wv_q [W_FRAC+1];
  w_stage_t ws_d [W_FRAC+1];
  w_stage_t ws_q [W_FRAC+1];

  always_comb begin
    wv_d[0]     = c1_v_q;
    ws_d[0].rem = RW_W'($unsigned(nn_q)) << W_FRAC;
    ws_d[0].q   = '0;
    ws_d[0].den = den_q;
    ws_d[0].fix = 1'b1;
    ws_d[0].wv  = W_ONE;
    if (!cfg_i.spot_mode || zero_q) begin
      ws_d[0].wv = W_ONE;
    end else if (eq_q) begin
      // hard edge
      ws_d[0].wv = hard_q ? W_ONE : '0;
    end else if (nn_q <= 0) begin
      ws_d[0].wv = '0;
    end else if ($unsigned(nn_q) >= NB_W'(den_q)) begin
      ws_d[0].wv = W_ONE;
    end else begin
      ws_d[0].fix = 1'b0;
    end
  end

  for (genvar j = 0; j < W_FRAC; j++) begin : g_w
    localparam int K = W_FRAC - 1 - j;
    logic [RW_W-1:0] dsh;
    always_comb begin
      dsh = RW_W'(ws_q[j].den) << K;
      ws_d[j+1] = ws_q[j];
      if (ws_q[j].rem >= dsh) begin
        ws_d[j+1].rem = ws_q[j].rem - dsh;
        ws_d[j+1].q   = ws_q[j].q | (W_FRAC'(1) << K);
      end
    end
    assign wv_d[j+1] = wv_q[j];
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_v_q <= 1'b0;
      for (int j = 0; j <= QC_W; j++) cv_q[j] <= 1'b0;
      for (int j = 0; j <= W_FRAC; j++) wv_q[j] <= 1'b0;
    end else begin
      c1_v_q <= cv_q[QC_W];
      for (int j = 0; j <= QC_W; j++) cv_q[j] <= cv_d[j];
      for (int j = 0; j <= W_FRAC; j++) wv_q[j] <= wv_d[j];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    cd_q   <= cd_d;
    nn_q   <= nn_d;
    den_q  <= den_d;
    eq_q   <= eq_d;
    hard_q <= hard_d;
    zero_q <= cd_q[QC_W].zero;
    ws_q   <= ws_d;
  end

  assign cone_o.valid = wv_q[W_FRAC];
  assign cone_o.w     = ws_q[W_FRAC].fix ? ws_q[W_FRAC].wv : W_W'(ws_q[W_FRAC].q);

endmodule

`default_nettype wire
